[src/nfpa_pkg.sv]
package nfpa_pkg;

    // Default number of page slots in the claimed map.
    localparam int SLOTS_DEF = 4096;

    // Fixed field widths.
    localparam int CFG_W     = 13;
    localparam int COUNT_W   = 13;
    localparam int SLOT_W    = 12;
    localparam int CFG_IDX_W = 1;
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1;

    // Register reset values.
    localparam logic [CFG_W-1:0] KBASE_RESET = 13'd3072;
    localparam logic [CFG_W-1:0] TOP_RESET   = 13'd4096;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_PAGE    = 1'b1;

    // Action codes.
    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_SCAN,
        ST_CLAIM,
        ST_FREE,
        ST_RESULT
    } state_t;

endpackage

[src/next_fit_page_run_allocator_core.sv]
// Next-fit allocator of contiguous page-slot runs over a one-bit-per-slot claimed map.
// Input transfers on the s_ group carry one request: allocate count slots in the user
// or kernel region, or release count slots from start_slot. Each request gives exactly
// one result transfer on the m_ group: the first slot of the claimed run and an ok flag.
// The configuration port writes kernel_base_page (index 0) and top_page (index 1). It is
// to be written only while no request is in flight; the block itself does not enforce this.
// After reset the block sweeps the claimed map to all free, one slot per cycle, and
// s_tready stays low until that sweep is over.
// One request is worked on at a time through a single read/write port pair on the map.
// An allocation passes a setup state, then scans the region slot by slot through the
// registered map read, up to two passes when it rescans from the region base, then,
// if a run is found, claims its slots one by one, then hands over the result. A release
// passes the setup state, frees its slots one by one if in range, then hands over the result.
// The result sits in an output register and is held there while the receiver stalls.
// The next request may be taken and worked on meanwhile, but the block then waits in
// its result stage, with s_tready low, until the held result has been transferred.
module next_fit_page_run_allocator_core #(
    parameter int SLOTS = nfpa_pkg::SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // Configuration write port.
    input  logic                            cfg_we,
    input  logic [nfpa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nfpa_pkg::CFG_W-1:0]      cfg_data,
    // Request stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [nfpa_pkg::S_TDATA_W-1:0]  s_tdata,   // count[12:0], start_slot[24:13], zeros
    input  logic [nfpa_pkg::S_TUSER_W-1:0]  s_tuser,   // action[0], user_region[1]
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [nfpa_pkg::M_TDATA_W-1:0]  m_tdata,   // first_slot[11:0], zeros
    output logic [nfpa_pkg::M_TUSER_W-1:0]  m_tuser    // ok[0]
);

    // Address width of the map, and a common width for slot arithmetic that holds both
    // SLOTS itself and any register value.
    localparam int IDX_W = $clog2(SLOTS);
    localparam int W     = (IDX_W + 1 > nfpa_pkg::CFG_W) ? IDX_W + 1 : nfpa_pkg::CFG_W;
    localparam logic [W-1:0] SLOTS_W = W'(SLOTS);
    localparam logic [W-1:0] LAST_W  = W'(SLOTS - 1);

    nfpa_pkg::state_t state_reg, state_next;

    logic [nfpa_pkg::CFG_W-1:0] kbase_reg, kbase_next;
    logic [nfpa_pkg::CFG_W-1:0] top_reg, top_next;
    logic [W-1:0] user_resume_reg, user_resume_next;
    logic [W-1:0] kern_resume_reg, kern_resume_next;

    // Request held for the duration of the work.
    logic         act_reg, act_next;
    logic         user_reg, user_next;
    logic [W-1:0] count_reg, count_next;
    logic [W-1:0] start_reg, start_next;

    // Scan and sweep control.
    logic [W-1:0] base_reg, base_next;
    logic [W-1:0] end_reg, end_next;
    logic [W-1:0] scan_reg, scan_next;
    logic [W-1:0] chk_reg, chk_next;
    logic         rd_valid_reg, rd_valid_next;
    logic [W-1:0] run_reg, run_next;
    logic [W-1:0] first_reg, first_next;
    logic [W-1:0] last_reg, last_next;
    logic         rescan_reg, rescan_next;
    logic         res_ok_reg, res_ok_next;

    // Output register.
    logic                         out_valid_reg, out_valid_next;
    logic [nfpa_pkg::SLOT_W-1:0]  out_first_reg, out_first_next;
    logic                         out_ok_reg, out_ok_next;

    // Map port.
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic             ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic             ram_rdata;

    // Request fields.
    logic                           in_act;
    logic                           in_user;
    logic [nfpa_pkg::COUNT_W-1:0]   in_count;
    logic [nfpa_pkg::SLOT_W-1:0]    in_start;

    assign in_act   = s_tuser[0];
    assign in_user  = s_tuser[1];
    assign in_count = s_tdata[nfpa_pkg::COUNT_W-1:0];
    assign in_start = s_tdata[nfpa_pkg::COUNT_W +: nfpa_pkg::SLOT_W];

    // Region bounds, clipped to the size of the map.
    logic [W-1:0] kb_clip, top_clip, base_c, end_c, resume_c, from_c;
    logic [W:0]   rel_end_c;
    logic         alloc_fail_c, rel_fail_c;

    always_comb
    begin
        kb_clip   = (W'(kbase_reg) > SLOTS_W) ? SLOTS_W : W'(kbase_reg);
        top_clip  = (W'(top_reg) > SLOTS_W) ? SLOTS_W : W'(top_reg);
        base_c    = user_reg ? '0 : kb_clip;
        end_c     = user_reg ? kb_clip : top_clip;
        resume_c  = user_reg ? user_resume_reg : kern_resume_reg;
        // A resume pointer left outside its region by a register change starts at the base.
        from_c    = (resume_c < base_c || resume_c >= end_c) ? base_c : resume_c;
        alloc_fail_c = (count_reg == '0) || (base_c >= end_c);
        rel_end_c    = (W + 1)'(start_reg) + (W + 1)'(count_reg);
        rel_fail_c   = rel_end_c > (W + 1)'(SLOTS_W);
    end

    // Scan flags: a read is issued while the cursor is inside the region, and the data of
    // each read is checked in the cycle after it is issued.
    logic         issue_c;
    logic [W-1:0] run_inc_c;
    logic         hit_c;
    logic         pass_end_c;
    logic [W-1:0] run_first_c;

    assign issue_c     = scan_reg != end_reg;
    assign run_inc_c   = run_reg + W'(1);
    assign hit_c       = rd_valid_reg && !ram_rdata && (run_inc_c == count_reg);
    assign pass_end_c  = !rd_valid_reg && !issue_c;
    assign run_first_c = (run_reg == '0) ? chk_reg : first_reg;

    logic accept_c;
    logic out_load_c;

    assign accept_c   = s_tvalid && s_tready;
    assign out_load_c = (state_reg == nfpa_pkg::ST_RESULT) && (!out_valid_reg || m_tready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nfpa_pkg::ST_CLEAR:
            begin
                if (scan_reg == LAST_W)
                begin
                    state_next = nfpa_pkg::ST_IDLE;
                end
            end
            nfpa_pkg::ST_IDLE:
            begin
                if (accept_c)
                begin
                    state_next = nfpa_pkg::ST_SETUP;
                end
            end
            nfpa_pkg::ST_SETUP:
            begin
                if (act_reg == nfpa_pkg::ACT_RELEASE)
                begin
                    state_next = rel_fail_c ? nfpa_pkg::ST_RESULT : nfpa_pkg::ST_FREE;
                end
                else
                begin
                    state_next = alloc_fail_c ? nfpa_pkg::ST_RESULT : nfpa_pkg::ST_SCAN;
                end
            end
            nfpa_pkg::ST_SCAN:
            begin
                if (hit_c)
                begin
                    state_next = nfpa_pkg::ST_CLAIM;
                end
                else if (pass_end_c && !rescan_reg)
                begin
                    state_next = nfpa_pkg::ST_RESULT;
                end
            end
            nfpa_pkg::ST_CLAIM:
            begin
                if (scan_reg == last_reg)
                begin
                    state_next = nfpa_pkg::ST_RESULT;
                end
            end
            nfpa_pkg::ST_FREE:
            begin
                if (!issue_c)
                begin
                    state_next = nfpa_pkg::ST_RESULT;
                end
            end
            nfpa_pkg::ST_RESULT:
            begin
                if (out_load_c)
                begin
                    state_next = nfpa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nfpa_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and map port.
    always_comb
    begin
        kbase_next       = kbase_reg;
        top_next         = top_reg;
        user_resume_next = user_resume_reg;
        kern_resume_next = kern_resume_reg;
        act_next         = act_reg;
        user_next        = user_reg;
        count_next       = count_reg;
        start_next       = start_reg;
        base_next        = base_reg;
        end_next         = end_reg;
        scan_next        = scan_reg;
        chk_next         = chk_reg;
        rd_valid_next    = 1'b0;
        run_next         = run_reg;
        first_next       = first_reg;
        last_next        = last_reg;
        rescan_next      = rescan_reg;
        res_ok_next      = res_ok_reg;
        out_valid_next   = out_valid_reg;
        out_first_next   = out_first_reg;
        out_ok_next      = out_ok_reg;
        ram_we           = 1'b0;
        ram_waddr        = scan_reg[IDX_W-1:0];
        ram_wdata        = 1'b0;
        ram_raddr        = scan_reg[IDX_W-1:0];
        s_tready         = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                nfpa_pkg::REG_KERNEL_BASE: kbase_next = cfg_data;
                nfpa_pkg::REG_TOP_PAGE:    top_next   = cfg_data;
                default:                   ;
            endcase
        end

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            nfpa_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = 1'b0;
                scan_next = scan_reg + W'(1);
            end
            nfpa_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (accept_c)
                begin
                    act_next   = in_act;
                    user_next  = in_user;
                    count_next = W'(in_count);
                    start_next = W'(in_start);
                end
            end
            nfpa_pkg::ST_SETUP:
            begin
                res_ok_next = 1'b0;
                if (act_reg == nfpa_pkg::ACT_RELEASE)
                begin
                    scan_next = start_reg;
                    end_next  = rel_end_c[W-1:0];
                    res_ok_next = !rel_fail_c;
                end
                else
                begin
                    base_next   = base_c;
                    end_next    = end_c;
                    scan_next   = from_c;
                    run_next    = '0;
                    rescan_next = from_c != base_c;
                end
            end
            nfpa_pkg::ST_SCAN:
            begin
                if (issue_c && !hit_c)
                begin
                    scan_next     = scan_reg + W'(1);
                    chk_next      = scan_reg;
                    rd_valid_next = 1'b1;
                end
                if (rd_valid_reg)
                begin
                    if (ram_rdata)
                    begin
                        run_next = '0;
                    end
                    else
                    begin
                        run_next   = run_inc_c;
                        first_next = run_first_c;
                    end
                end
                if (hit_c)
                begin
                    last_next = chk_reg;
                    scan_next = run_first_c;
                end
                else if (pass_end_c && rescan_reg)
                begin
                    // Second pass from the region base with the run counter cleared.
                    rescan_next = 1'b0;
                    scan_next   = base_reg;
                    run_next    = '0;
                    if (user_reg)
                    begin
                        user_resume_next = base_reg;
                    end
                    else
                    begin
                        kern_resume_next = base_reg;
                    end
                end
            end
            nfpa_pkg::ST_CLAIM:
            begin
                ram_we    = 1'b1;
                ram_wdata = 1'b1;
                scan_next = scan_reg + W'(1);
                if (scan_reg == last_reg)
                begin
                    res_ok_next = 1'b1;
                    if (user_reg)
                    begin
                        user_resume_next = last_reg;
                    end
                    else
                    begin
                        kern_resume_next = last_reg;
                    end
                end
            end
            nfpa_pkg::ST_FREE:
            begin
                if (issue_c)
                begin
                    ram_we    = 1'b1;
                    ram_wdata = 1'b0;
                    scan_next = scan_reg + W'(1);
                end
            end
            nfpa_pkg::ST_RESULT:
            begin
                if (out_load_c)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_first_next = (res_ok_reg && act_reg == nfpa_pkg::ACT_ALLOC)
                                     ? first_reg[nfpa_pkg::SLOT_W-1:0] : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= nfpa_pkg::ST_CLEAR;
            kbase_reg       <= nfpa_pkg::KBASE_RESET;
            top_reg         <= nfpa_pkg::TOP_RESET;
            user_resume_reg <= '0;
            kern_resume_reg <= W'(nfpa_pkg::KBASE_RESET);
            scan_reg        <= '0;
            rd_valid_reg    <= 1'b0;
            rescan_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            kbase_reg       <= kbase_next;
            top_reg         <= top_next;
            user_resume_reg <= user_resume_next;
            kern_resume_reg <= kern_resume_next;
            scan_reg        <= scan_next;
            rd_valid_reg    <= rd_valid_next;
            rescan_reg      <= rescan_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        user_reg      <= user_next;
        count_reg     <= count_next;
        start_reg     <= start_next;
        base_reg      <= base_next;
        end_reg       <= end_next;
        chk_reg       <= chk_next;
        run_reg       <= run_next;
        first_reg     <= first_next;
        last_reg      <= last_next;
        res_ok_reg    <= res_ok_next;
        out_first_reg <= out_first_next;
        out_ok_reg    <= out_ok_next;
    end

    nfpa_ram #(
        .WIDTH (1),
        .DEPTH (SLOTS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = nfpa_pkg::M_TDATA_W'(out_first_reg);
    assign m_tuser  = out_ok_reg;

endmodule

[src/nfpa_ram.sv]
module nfpa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = nfpa_pkg::SLOTS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[tb/tb_next_fit_page_run_allocator_core.sv]
module tb_next_fit_page_run_allocator_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS = nfpa_pkg::SLOTS_DEF;

    // One expected result transfer: the first slot of the claimed run and the success flag.
    typedef struct {
        logic [nfpa_pkg::SLOT_W-1:0] first_slot;
        logic                        ok;
    } outcome_t;

    // A run that the allocator handed out, kept so that later releases can return it.
    typedef struct {
        int unsigned head;
        int unsigned length;
    } slot_run_t;

    // The scoreboard carries its own copy of the slot map, the two resume pointers and the
    // region registers. Each accepted request is played against that copy to give the
    // expected result, which waits in a queue until the matching result transfer arrives.
    class alloc_scoreboard;
        bit          slot_taken [TABLE_SLOTS];
        int unsigned kernel_base;
        int unsigned top_bound;
        int unsigned user_next;
        int unsigned kernel_next;
        outcome_t    expected_q[$];
        slot_run_t   live_runs[$];
        int          errors;

        function new();
            kernel_base = nfpa_pkg::KBASE_RESET;
            top_bound   = nfpa_pkg::TOP_RESET;
            user_next   = 0;
            kernel_next = nfpa_pkg::KBASE_RESET;
            errors      = 0;
        endfunction

        function void set_register(logic [nfpa_pkg::CFG_IDX_W-1:0] index,
                                   logic [nfpa_pkg::CFG_W-1:0] value);
            if (index == nfpa_pkg::REG_KERNEL_BASE)
                kernel_base = value;
            else
                top_bound = value;
        endfunction

        function int unsigned clip_slots(int unsigned v);
            return (v > TABLE_SLOTS) ? TABLE_SLOTS : v;
        endfunction

        // Looks for len free slots in a row within [from, stop).
        function bit scan_for_run(int unsigned from, int unsigned stop, int unsigned len,
                                  output int unsigned first, output int unsigned last);
            int unsigned i;
            int unsigned run;
            int unsigned head;
            run   = 0;
            head  = 0;
            first = 0;
            last  = 0;
            for (i = from; i < stop; i++) begin
                if (!slot_taken[i]) begin
                    if (run == 0)
                        head = i;
                    run++;
                end else begin
                    run = 0;
                end
                if (run == len) begin
                    first = head;
                    last  = i;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_request(logic action, logic [nfpa_pkg::COUNT_W-1:0] count,
                                   logic user, logic [nfpa_pkg::SLOT_W-1:0] start);
            int unsigned kb;
            int unsigned base;
            int unsigned stop;
            int unsigned from;
            int unsigned first;
            int unsigned last;
            int unsigned j;
            bit          found;
            outcome_t    res;
            found = 1'b0;
            first = 0;
            last  = 0;
            if (action == nfpa_pkg::ACT_ALLOC) begin
                kb   = clip_slots(kernel_base);
                base = user ? 0 : kb;
                stop = user ? kb : clip_slots(top_bound);
                from = user ? user_next : kernel_next;
                if (from < base || from >= stop)
                    from = base;
                if (count != 0 && base < stop) begin
                    found = scan_for_run(from, stop, count, first, last);
                    // A failed first pass rescans once from the region base.
                    if (!found && from != base) begin
                        if (user)
                            user_next = base;
                        else
                            kernel_next = base;
                        found = scan_for_run(base, stop, count, first, last);
                    end
                    if (found) begin
                        if (user)
                            user_next = last;
                        else
                            kernel_next = last;
                        for (j = first; j <= last; j++)
                            slot_taken[j] = 1'b1;
                        live_runs.push_back('{head: first, length: count});
                    end
                end
                if (!found)
                    first = 0;
            end else begin
                if (int'(start) + int'(count) <= TABLE_SLOTS) begin
                    for (j = 0; j < count; j++)
                        slot_taken[start + j] = 1'b0;
                    found = 1'b1;
                end
                first = 0;
            end
            res.first_slot = first[nfpa_pkg::SLOT_W-1:0];
            res.ok         = found;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [nfpa_pkg::SLOT_W-1:0] first_slot, logic ok);
            outcome_t exp_res;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual first_slot=%0d ok=%0b",
                         $time, first_slot, ok);
                errors++;
            end else begin
                exp_res = expected_q.pop_front();
                if (first_slot !== exp_res.first_slot) begin
                    $display("%0t: first_slot mismatch, expected %0d, actual %0d",
                             $time, exp_res.first_slot, first_slot);
                    errors++;
                end
                if (ok !== exp_res.ok) begin
                    $display("%0t: ok mismatch, expected %0b, actual %0b",
                             $time, exp_res.ok, ok);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [nfpa_pkg::CFG_IDX_W-1:0] cfg_index = nfpa_pkg::REG_KERNEL_BASE;
    logic [nfpa_pkg::CFG_W-1:0]     cfg_data  = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [nfpa_pkg::S_TDATA_W-1:0] s_tdata   = '0;   // count[12:0], start_slot[24:13], zeros
    logic [nfpa_pkg::S_TUSER_W-1:0] s_tuser   = '0;   // action[0], user_region[1]
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [nfpa_pkg::M_TDATA_W-1:0] m_tdata;          // first_slot[11:0], zeros
    logic [nfpa_pkg::M_TUSER_W-1:0] m_tuser;          // ok[0]

    // Percentages of cycles in which the sender holds back or the receiver stalls.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    alloc_scoreboard sb = new();

    next_fit_page_run_allocator_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    // Result side. The values read here are those from just before the edge, as all of the
    // block's outputs and our own m_tready change by nonblocking assignment at the edge.
    // A transfer is checked first, then the ready line for the next cycle is chosen.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata[nfpa_pkg::SLOT_W-1:0], m_tuser[0]);
        m_tready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Presents one request and holds it until the transfer takes place. When the sender is
    // to idle, valid goes low for a random stretch first; otherwise valid stays high from
    // the previous transfer, so that back-to-back requests never see valid drop.
    task automatic send_request(logic action, int unsigned count, logic user,
                                int unsigned start);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, start[nfpa_pkg::SLOT_W-1:0], count[nfpa_pkg::COUNT_W-1:0]};
        s_tuser  <= {user, action};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(action, count[nfpa_pkg::COUNT_W-1:0], user,
                        start[nfpa_pkg::SLOT_W-1:0]);
    endtask

    // Stops the request stream and waits until every outstanding result has been taken.
    // Every request yields exactly one result, so the block is idle once the queue is
    // empty; the task still waits on past that point all the same.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes both region registers, one per cycle, and mirrors them in the scoreboard.
    task automatic write_registers(int unsigned kb, int unsigned top);
        cfg_we    <= 1'b1;
        cfg_index <= nfpa_pkg::REG_KERNEL_BASE;
        cfg_data  <= kb[nfpa_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_index <= nfpa_pkg::REG_TOP_PAGE;
        cfg_data  <= top[nfpa_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_register(nfpa_pkg::REG_KERNEL_BASE, kb[nfpa_pkg::CFG_W-1:0]);
        sb.set_register(nfpa_pkg::REG_TOP_PAGE, top[nfpa_pkg::CFG_W-1:0]);
    endtask

    // Random traffic for the current register setting. Most allocations ask for short runs
    // so that the map fragments without filling, and most releases hand back a run that
    // was really allocated. The rest is noise: long runs, odd releases, overruns of the
    // table end and the full width of the count field.
    task automatic run_random_phase(int n_items);
        int unsigned user_size;
        int unsigned kern_size;
        int unsigned sz;
        int unsigned count;
        int unsigned start;
        int unsigned pick;
        int unsigned idx;
        int unsigned cap;
        logic        user;
        slot_run_t   r;
        user_size = sb.clip_slots(sb.kernel_base);
        kern_size = (sb.clip_slots(sb.top_bound) > user_size) ?
                    sb.clip_slots(sb.top_bound) - user_size : 0;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 55) begin
                user = $urandom_range(0, 1);
                sz   = user ? user_size : kern_size;
                cap  = sz / 6;
                if (cap < 1)
                    cap = 1;
                if (cap > 48)
                    cap = 48;
                if (pick < 85)
                    count = $urandom_range(1, cap);
                else if (pick < 95)
                    count = $urandom_range(1, sz + 2);
                else
                    count = $urandom_range(0, 8191);
                send_request(nfpa_pkg::ACT_ALLOC, count, user, $urandom_range(0, 4095));
            end else begin
                if (pick < 60 && sb.live_runs.size() > 0) begin
                    idx = $urandom_range(0, sb.live_runs.size() - 1);
                    r   = sb.live_runs[idx];
                    sb.live_runs.delete(idx);
                    start = r.head;
                    count = r.length;
                end else if (pick < 85) begin
                    start = $urandom_range(0, 4095);
                    count = $urandom_range(0, 16);
                end else if (pick < 95) begin
                    start = $urandom_range(4000, 4095);
                    count = $urandom_range(1, 200);
                end else begin
                    start = $urandom_range(0, 4095);
                    count = $urandom_range(0, 8191);
                end
                send_request(nfpa_pkg::ACT_RELEASE, count, $urandom_range(0, 1), start);
            end
        end
        drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests with the reset register values and no idling on either side.
        // The block is still sweeping its map at first; the handshake simply waits.
        send_request(nfpa_pkg::ACT_ALLOC,   1,    1'b1, 0);     // first user slot
        send_request(nfpa_pkg::ACT_ALLOC,   0,    1'b1, 0);     // zero-length allocation fails
        send_request(nfpa_pkg::ACT_ALLOC,   1,    1'b0, 0);     // first kernel slot
        send_request(nfpa_pkg::ACT_ALLOC,   1024, 1'b0, 0);     // no room in the kernel region
        send_request(nfpa_pkg::ACT_ALLOC,   1023, 1'b0, 0);     // the rest of the kernel region
        send_request(nfpa_pkg::ACT_RELEASE, 1024, 1'b0, 3072);
        send_request(nfpa_pkg::ACT_RELEASE, 2,    1'b0, 4095);  // runs past the table end
        send_request(nfpa_pkg::ACT_RELEASE, 0,    1'b0, 5);     // zero-length release succeeds
        send_request(nfpa_pkg::ACT_RELEASE, 1,    1'b0, 4095);  // ends exactly at the table end
        send_request(nfpa_pkg::ACT_ALLOC,   8191, 1'b1, 4095);  // widest count, user region
        send_request(nfpa_pkg::ACT_ALLOC,   3071, 1'b1, 0);     // fills the user region
        send_request(nfpa_pkg::ACT_ALLOC,   1,    1'b1, 0);     // full region, resume to base
        send_request(nfpa_pkg::ACT_RELEASE, 20,   1'b1, 100);
        send_request(nfpa_pkg::ACT_ALLOC,   20,   1'b1, 0);     // hole found from the base
        send_request(nfpa_pkg::ACT_RELEASE, 4096, 1'b0, 0);     // whole table
        send_request(nfpa_pkg::ACT_RELEASE, 8,    1'b0, 10);    // slots already free
        send_request(nfpa_pkg::ACT_ALLOC,   1,    1'b0, 4095);  // resume pointer at the top slot
        send_request(nfpa_pkg::ACT_ALLOC,   2,    1'b0, 0);     // wraps round to the kernel base
        send_request(nfpa_pkg::ACT_RELEASE, 8191, 1'b1, 4095);  // widest count and slot
        drain();

        // Small regions: both resume pointers now lie outside their regions.
        write_registers(64, 192);
        send_idle_pct = 45;
        send_request(nfpa_pkg::ACT_ALLOC, 64, 1'b1, 0);
        run_random_phase(26);

        // The user region takes the whole table and the kernel region is empty.
        write_registers(4096, 8191);
        send_idle_pct  = 0;
        recv_stall_pct = 45;
        send_request(nfpa_pkg::ACT_RELEASE, 4096, 1'b0, 0);
        send_request(nfpa_pkg::ACT_ALLOC,   4096, 1'b1, 0);
        send_request(nfpa_pkg::ACT_ALLOC,   1,    1'b0, 0);
        run_random_phase(20);

        // The user region is empty and the kernel region spans the table.
        write_registers(0, 8191);
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        send_request(nfpa_pkg::ACT_ALLOC, 1, 1'b1, 0);
        run_random_phase(20);

        // Both bounds at their extremes the other way round.
        write_registers(8191, 0);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_phase(12);

        write_registers(200, 330);
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        run_random_phase(20);

        write_registers(nfpa_pkg::KBASE_RESET, nfpa_pkg::TOP_RESET);
        send_idle_pct  = 0;
        recv_stall_pct = 45;
        run_random_phase(20);

        // Give any stray result a chance to show up before the verdict.
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Guard against a hang.
    initial
    begin
        #16_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
src/nfpa_pkg.sv
src/nfpa_ram.sv
src/next_fit_page_run_allocator_core.sv
tb/tb_next_fit_page_run_allocator_core.sv
